// File: sv/mtd_pkg.sv
// package for the morse timing decoder: op codes, register indexes,
// timing limits and the letter lookup table; no dependencies
package mtd_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_RSSI_THRESHOLD   = 2'd0;
  localparam cfg_idx_t CFG_SAMPLE_PERIOD_MS = 2'd1;
  localparam cfg_idx_t CFG_TIMEOUT_MS       = 2'd2;

  localparam logic [7:0]  RESET_RSSI_THRESHOLD   = 8'hA6;
  localparam logic [7:0]  RESET_SAMPLE_PERIOD_MS = 8'd5;
  localparam logic [15:0] RESET_TIMEOUT_MS       = 16'd700;

  // duration windows, exclusive bounds in ms
  localparam logic [15:0] DOT_LO    = 16'd29;
  localparam logic [15:0] DOT_HI    = 16'd91;
  localparam logic [15:0] DASH_LO   = 16'd149;
  localparam logic [15:0] DASH_HI   = 16'd211;
  localparam logic [15:0] LETTER_HI = 16'd271;
  localparam logic [15:0] WORD1_LO  = 16'd389;
  localparam logic [15:0] WORD1_HI  = 16'd451;
  localparam logic [15:0] WORD2_LO  = 16'd569;
  localparam logic [15:0] WORD2_HI  = 16'd691;

  localparam int unsigned QUEUE_DEPTH = 4;

  typedef enum logic [2:0] {
    OP_SHIFT0,
    OP_SHIFT1,
    OP_SHIFT3,
    OP_END,
    OP_END_SPACE,
    OP_CLEAR,
    OP_TIMEOUT
  } op_e;

  typedef struct packed {
    logic     we;
    cfg_idx_t idx;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  localparam int unsigned NUM_CODES  = 36;
  localparam logic [6:0]  CHAR_SPACE = 7'h20;

  localparam logic [31:0] CODE_PATTERN [NUM_CODES] = '{
    32'h17, 32'h1D5, 32'h75D, 32'h75, 32'h01, 32'h15D, 32'h1DD, 32'h55, 32'h05,
    32'h1777, 32'h1D7, 32'h175, 32'h77, 32'h1D, 32'h777, 32'h5DD, 32'h1DD7, 32'h5D,
    32'h15, 32'h07, 32'h57, 32'h157, 32'h177, 32'h757, 32'h1D77, 32'h775,
    32'h17777, 32'h5777, 32'h1577, 32'h557, 32'h155, 32'h755, 32'h1DD5, 32'h7775,
    32'h1DDDD, 32'h77777
  };

  localparam logic [6:0] CODE_CHAR [NUM_CODES] = '{
    7'h41, 7'h42, 7'h43, 7'h44, 7'h45, 7'h46, 7'h47, 7'h48, 7'h49,
    7'h4A, 7'h4B, 7'h4C, 7'h4D, 7'h4E, 7'h4F, 7'h50, 7'h51, 7'h52,
    7'h53, 7'h54, 7'h55, 7'h56, 7'h57, 7'h58, 7'h59, 7'h5A,
    7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
    7'h39, 7'h30
  };

  function automatic logic [6:0] lookup_char(input logic [31:0] pattern);
    logic [6:0] c;
    c = 7'd0;
    for (int i = 0; i < NUM_CODES; i++) begin
      if (pattern == CODE_PATTERN[i]) c = CODE_CHAR[i];
    end
    return c;
  endfunction

endpackage

// File: sv/mtd_front.sv
// front end: config registers, carrier detect, stretch timing and
// classification into ops; depends on mtd_pkg
module mtd_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  mtd_pkg::cfg_wr_t cfg_i,
  input  logic            sample_valid_i,
  output logic            sample_ready_o,
  input  logic [7:0]      sample_rssi_i,
  input  logic            queue_full_i,
  output logic            push_o,
  output mtd_pkg::op_e    push_op_o
);
  import mtd_pkg::*;

  logic [7:0]  thr_q, period_q;
  logic [15:0] timeout_q;
  logic        was_on_q, was_on_d;
  logic [15:0] elapsed_q, elapsed_d;
  logic [16:0] sum;
  logic [15:0] dur;
  logic        on, fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q     <= RESET_RSSI_THRESHOLD;
      period_q  <= RESET_SAMPLE_PERIOD_MS;
      timeout_q <= RESET_TIMEOUT_MS;
    end else if (cfg_i.we) begin
      unique case (cfg_i.idx)
        CFG_RSSI_THRESHOLD:   thr_q     <= cfg_i.data[7:0];
        CFG_SAMPLE_PERIOD_MS: period_q  <= cfg_i.data[7:0];
        CFG_TIMEOUT_MS:       timeout_q <= cfg_i.data[15:0];
        default: ;
      endcase
    end
  end

  assign sample_ready_o = !queue_full_i;
  assign fire = sample_valid_i && sample_ready_o;
  assign on   = $signed(sample_rssi_i) > $signed(thr_q);
  assign sum  = {1'b0, elapsed_q} + {9'd0, period_q};
  assign dur  = sum[16] ? 16'hFFFF : sum[15:0];

  always_comb begin
    was_on_d  = was_on_q;
    elapsed_d = elapsed_q;
    push_o    = 1'b0;
    push_op_o = OP_CLEAR;
    if (fire) begin
      was_on_d  = on;
      elapsed_d = dur;
      if (on && !was_on_q) begin
        elapsed_d = 16'd0;
        push_o    = 1'b1;
        if (dur > DOT_LO && dur < DOT_HI) push_op_o = OP_SHIFT0;
        else if (dur > DASH_LO && dur < LETTER_HI) push_op_o = OP_END;
        else if ((dur > WORD1_LO && dur < WORD1_HI) || (dur > WORD2_LO && dur < WORD2_HI))
          push_op_o = OP_END_SPACE;
        else push_op_o = OP_CLEAR;
      end else if (!on && was_on_q) begin
        elapsed_d = 16'd0;
        push_o    = 1'b1;
        if (dur > DOT_LO && dur < DOT_HI) push_op_o = OP_SHIFT1;
        else if (dur > DASH_LO && dur < DASH_HI) push_op_o = OP_SHIFT3;
        else push_op_o = OP_CLEAR;
      end else if (!on && dur > timeout_q) begin
        push_o    = 1'b1;
        push_op_o = OP_TIMEOUT;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      was_on_q  <= 1'b0;
      elapsed_q <= 16'd0;
    end else begin
      was_on_q  <= was_on_d;
      elapsed_q <= elapsed_d;
    end
  end

endmodule

// File: sv/mtd_fifo.sv
// short op queue between front and back end
// depends on mtd_pkg for the op type and depth
module mtd_fifo (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  mtd_pkg::op_e data_i,
  output logic         full_o,
  input  logic         pop_i,
  output mtd_pkg::op_e data_o,
  output logic         empty_o
);
  import mtd_pkg::*;

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  op_e           entries_q [QUEUE_DEPTH];
  logic [PW-1:0] wptr_q, rptr_q;
  logic [CW-1:0] count_q;
  logic          do_push, do_pop;

  assign full_o  = (count_q == CW'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = entries_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) entries_q[wptr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (do_push) wptr_q <= (wptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      if (do_pop)  rptr_q <= (rptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      if (do_push && !do_pop) count_q <= count_q + 1'b1;
      else if (do_pop && !do_push) count_q <= count_q - 1'b1;
    end
  end

endmodule

// File: sv/mtd_back.sv
// back end: symbol shift register, letter lookup, frame store and
// frame emission through an output register; depends on mtd_pkg
module mtd_back #(
  parameter int unsigned FRAME_DEPTH  = 64,
  parameter int unsigned MAX_ELEMENTS = 20
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         op_valid_i,
  input  mtd_pkg::op_e op_i,
  output logic         pop_o,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output logic [6:0]   out_char_o,
  output logic         out_last_o
);
  import mtd_pkg::*;

  localparam int unsigned AW = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;
  localparam int unsigned LW = $clog2(FRAME_DEPTH + 1);
  localparam int unsigned CW = $clog2(MAX_ELEMENTS + 1);

  localparam logic [1:0] ST_IDLE      = 2'd0;
  localparam logic [1:0] ST_SPACE     = 2'd1;
  localparam logic [1:0] ST_EMIT_RD   = 2'd2;
  localparam logic [1:0] ST_EMIT_WAIT = 2'd3;

  logic [1:0]    state_q, state_d;
  logic [31:0]   sym_q, sym_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [LW-1:0] len_q, len_d;
  logic [LW-1:0] idx_q, idx_d;
  logic          room, we, rd_en, load;
  logic [AW-1:0] waddr;
  logic [6:0]    wdata;
  logic [6:0]    mem_q [FRAME_DEPTH];
  logic [6:0]    rdata_q;
  logic          out_valid_q;
  logic [6:0]    out_char_q;
  logic          out_last_q;
  logic          is_last;

  function automatic logic [CW-1:0] count_inc(input logic [CW-1:0] c);
    logic [CW:0] n;
    n = {1'b0, c} + 1'b1;
    return (n > (CW + 1)'(MAX_ELEMENTS)) ? '0 : n[CW-1:0];
  endfunction

  assign room    = (len_q < LW'(FRAME_DEPTH));
  assign waddr   = len_q[AW-1:0];
  assign is_last = ((idx_q + 1'b1) >= len_q);

  always_comb begin
    state_d = state_q;
    sym_d   = sym_q;
    cnt_d   = cnt_q;
    len_d   = len_q;
    idx_d   = idx_q;
    pop_o   = 1'b0;
    we      = 1'b0;
    wdata   = lookup_char(sym_q);
    rd_en   = 1'b0;
    load    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (op_valid_i) begin
          pop_o = 1'b1;
          case (op_i)
            OP_SHIFT0: begin
              sym_d = {sym_q[30:0], 1'b0};
              cnt_d = count_inc(cnt_q);
            end
            OP_SHIFT1: begin
              sym_d = {sym_q[30:0], 1'b1};
              cnt_d = count_inc(cnt_q);
            end
            OP_SHIFT3: begin
              sym_d = {sym_q[28:0], 3'b111};
              cnt_d = count_inc(count_inc(count_inc(cnt_q)));
            end
            OP_END, OP_END_SPACE: begin
              we    = room;
              len_d = room ? len_q + 1'b1 : len_q;
              sym_d = '0;
              cnt_d = '0;
              if (op_i == OP_END_SPACE) state_d = ST_SPACE;
            end
            OP_TIMEOUT: begin
              if (cnt_q != '0) begin
                we      = room;
                len_d   = room ? len_q + 1'b1 : len_q;
                sym_d   = '0;
                cnt_d   = '0;
                idx_d   = '0;
                state_d = ST_EMIT_RD;
              end
            end
            default: begin
              sym_d = '0;
              cnt_d = '0;
              len_d = '0;
            end
          endcase
        end
      end
      ST_SPACE: begin
        wdata   = CHAR_SPACE;
        we      = room;
        len_d   = room ? len_q + 1'b1 : len_q;
        state_d = ST_IDLE;
      end
      ST_EMIT_RD: begin
        rd_en   = 1'b1;
        state_d = ST_EMIT_WAIT;
      end
      ST_EMIT_WAIT: begin
        if (!out_valid_q || out_ready_i) begin
          load = 1'b1;
          if (is_last) begin
            len_d   = '0;
            state_d = ST_IDLE;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = ST_EMIT_RD;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
    if (rd_en) rdata_q <= mem_q[idx_q[AW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sym_q       <= '0;
      cnt_q       <= '0;
      len_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      sym_q   <= sym_d;
      cnt_q   <= cnt_d;
      len_q   <= len_d;
      idx_q   <= idx_d;
      if (load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_char_q <= rdata_q;
      out_last_q <= is_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign out_last_o  = out_last_q;

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LW'(FRAME_DEPTH))
    else $error("frame length beyond store depth");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MAX_ELEMENTS))
    else $error("element count beyond wrap limit");

  a_emit_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT_RD) |-> (idx_q < len_q))
    else $error("emission reads past frame end");

  a_no_pop_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !pop_o)
    else $error("op taken while back end busy");

endmodule

// File: sv/morse_timing_decoder.sv
// top level of the morse timing decoder: front end, op queue, back end
// depends on mtd_pkg, mtd_front, mtd_fifo and mtd_back
//
// One 8-bit signed rssi sample is taken per cycle while the four-entry op
// queue has room; the front end times on and off stretches and queues one op
// per edge or timeout sample. The back end retires a queued op only while idle;
// a letter end with space then stores the space character in ST_SPACE. A
// timeout with pending elements emits the whole frame, each character passing
// through the registered frame store read into the output register; the output
// side may stall freely; ops then queue until the op queue fills and stalls samples.
module morse_timing_decoder #(
  parameter int unsigned FRAME_DEPTH  = 64,
  parameter int unsigned MAX_ELEMENTS = 20
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  mtd_pkg::cfg_idx_t    cfg_idx_i,
  input  logic [15:0]          cfg_data_i,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,   // [7:0] rssi
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [7:0]           m_axis_tdata,   // [6:0] char_code, [7] zero
  output logic                 m_axis_tlast
);
  import mtd_pkg::*;

  cfg_wr_t    cfg;
  logic       q_full, q_empty, q_push, q_pop;
  op_e        q_in, q_out;
  logic [6:0] out_char;

  assign cfg.we   = cfg_we_i;
  assign cfg.idx  = cfg_idx_i;
  assign cfg.data = cfg_data_i;

  mtd_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .sample_valid_i (s_axis_tvalid),
    .sample_ready_o (s_axis_tready),
    .sample_rssi_i  (s_axis_tdata),
    .queue_full_i   (q_full),
    .push_o         (q_push),
    .push_op_o      (q_in)
  );

  mtd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_out),
    .empty_o (q_empty)
  );

  mtd_back #(
    .FRAME_DEPTH  (FRAME_DEPTH),
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_valid_i  (!q_empty),
    .op_i        (q_out),
    .pop_o       (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_char_o  (out_char),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {1'b0, out_char};

endmodule
